// ===== rtl/fba_pkg.sv =====
// Shared constants for the frame bitmap allocator: sizes, widths,
// operation codes and status codes. No dependencies.
package fba_pkg;

  localparam int MAX_FRAMES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int NWORDS     = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;

  localparam int FRAME_W = 12;            // frame number field
  localparam int LIM_W   = 13;            // frames_in_use register
  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int WIDX_W  = $clog2(NWORDS);

  // operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_ALREADY  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_FREE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTHING  = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE    = 3'd4;

  localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(MAX_FRAMES);

endpackage

// ===== rtl/fba_if.sv =====
// Valid/ready channel interfaces for the frame bitmap allocator:
// request, result and configuration write. Depends on fba_pkg.
interface fba_in_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::OP_W-1:0]     op;
  logic [fba_pkg::FRAME_W-1:0]  current_frame;
  logic                         kernel_page;
  logic                         writable;

  modport source (output valid, op, current_frame, kernel_page, writable, input ready);
  modport sink   (input valid, op, current_frame, kernel_page, writable, output ready);
endinterface

interface fba_out_if;
  logic                         valid;
  logic                         ready;
  logic [fba_pkg::FRAME_W-1:0]  frame;
  logic                         present;
  logic                         write_enable;
  logic                         user_mode;
  logic                         bit_set;
  logic [fba_pkg::STAT_W-1:0]   status;

  modport source (output valid, frame, present, write_enable, user_mode, bit_set, status,
                  input ready);
  modport sink   (input valid, frame, present, write_enable, user_mode, bit_set, status,
                  output ready);
endinterface

interface fba_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fba_pkg::LIM_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/frame_bitmap_allocator_top.sv =====
// Frame bitmap allocator, first fit, with the used/free bitmap in one RAM.
// Depends on fba_pkg and the channel interfaces in fba_if.sv.
//
//   channel  | dir | payload                                             | beat when
//   ---------+-----+-----------------------------------------------------+------------------
//   in_if    | in  | op, current_frame, kernel_page, writable            | valid & ready
//   out_if   | out | frame, present, write_enable, user_mode, bit_set,   | valid & ready
//            |     | status                                              |
//   cfg_if   | in  | data = frames_in_use                                | valid & ready
//
// Flow: one request at a time. Requests answered without the bitmap
// (already allocated, bad frame, bad op) go from S_IDLE straight to S_OUT;
// free and test pass through S_SCAN (one RAM read; free then writes back).
// Allocate scans the bitmap RAM one word a cycle from word 0, reading k
// words, k <= 128, through the single read port of the bitmap RAM.
// Reset: 128 word-valid flops clear at once; a word never written reads as
// all free, so no clearing pass is needed. frames_in_use resets to 4096.
// Stalls: the result sits in an output register; a new request is taken
// while it waits, and a finished result holds in S_OUT until that slot frees.
module frame_bitmap_allocator_top (
  input  logic       clk,
  input  logic       rst_n,
  fba_in_if.sink     in_if,
  fba_out_if.source  out_if,
  fba_cfg_if.sink    cfg_if
);

  typedef struct packed {
    logic [fba_pkg::FRAME_W-1:0] frame;
    logic                        present;
    logic                        write_enable;
    logic                        user_mode;
    logic                        bit_set;
    logic [fba_pkg::STAT_W-1:0]  status;
  } res_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OUT} state_t;

  localparam res_t RES_ZERO = '0;

  // lowest clear bit of a word
  function automatic logic [fba_pkg::BIT_W-1:0] low_zero(
    input logic [fba_pkg::WORD_BITS-1:0] w
  );
    logic [fba_pkg::BIT_W-1:0] p;
    p = '0;
    for (int i = fba_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) p = fba_pkg::BIT_W'(i);
    end
    return p;
  endfunction

  state_t                          state_r, state_nxt;
  logic [fba_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [fba_pkg::FRAME_W-1:0]     cur_r, cur_nxt;
  logic                            kern_r, kern_nxt;
  logic                            wr_r, wr_nxt;
  logic [fba_pkg::WIDX_W-1:0]      addr_r, addr_nxt;
  res_t                            res_r, res_nxt;
  res_t                            out_res_r, out_res_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [fba_pkg::LIM_W-1:0]       frames_in_use_r;

  // bitmap RAM and per-word valid flops
  logic [fba_pkg::WORD_BITS-1:0]   mem [fba_pkg::NWORDS];
  logic [fba_pkg::NWORDS-1:0]      wvld_r;
  logic [fba_pkg::WORD_BITS-1:0]   rd_data_r;
  logic                            rd_vld_r;
  logic                            wr_en;
  logic [fba_pkg::WORD_BITS-1:0]   wr_data;

  logic [fba_pkg::LIM_W-1:0]       lim;
  logic [fba_pkg::WORD_BITS-1:0]   word;
  logic [fba_pkg::WORD_BITS-1:0]   bmask;
  logic [fba_pkg::BIT_W-1:0]       zpos;
  logic [fba_pkg::FRAME_W-1:0]     found;
  logic [fba_pkg::WIDX_W:0]        next_word;
  logic [fba_pkg::LIM_W-1:0]       next_base;
  logic                            all_used;
  logic                            in_beat;
  logic                            in_range;
  logic                            out_free;

  assign lim = (frames_in_use_r > fba_pkg::LIM_RESET) ? fba_pkg::LIM_RESET : frames_in_use_r;

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_beat      = in_if.valid && in_if.ready;
  assign in_range     = ({1'b0, in_if.current_frame} < lim);
  assign out_free     = !out_valid_r || out_if.ready;

  // word under evaluation; unwritten words are all free
  assign word      = rd_vld_r ? rd_data_r : '0;
  assign zpos      = low_zero(word);
  assign all_used  = &word;
  assign found     = {addr_r, zpos};
  assign next_word = {1'b0, addr_r} + (fba_pkg::WIDX_W + 1)'(1);
  assign next_base = {next_word, fba_pkg::BIT_W'(0)};
  assign bmask     = fba_pkg::WORD_BITS'(1) << cur_r[fba_pkg::BIT_W-1:0];

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    cur_nxt       = cur_r;
    kern_nxt      = kern_r;
    wr_nxt        = wr_r;
    addr_nxt      = addr_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    wr_en         = 1'b0;
    wr_data       = word;

    case (state_r)
      S_IDLE: begin
        if (in_beat) begin
          op_nxt   = in_if.op;
          cur_nxt  = in_if.current_frame;
          kern_nxt = in_if.kernel_page;
          wr_nxt   = in_if.writable;
          res_nxt  = RES_ZERO;
          addr_nxt = in_if.current_frame[fba_pkg::FRAME_W-1:fba_pkg::BIT_W];
          case (in_if.op)
            fba_pkg::OP_ALLOC: begin
              if (in_if.current_frame != '0) begin
                res_nxt.frame  = in_if.current_frame;
                res_nxt.status = fba_pkg::ST_ALREADY;
                state_nxt      = S_OUT;
              end else begin
                addr_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            fba_pkg::OP_FREE: begin
              if (in_if.current_frame == '0) begin
                res_nxt.status = fba_pkg::ST_NOTHING;
                state_nxt      = S_OUT;
              end else if (!in_range) begin
                res_nxt.frame  = in_if.current_frame;
                res_nxt.status = fba_pkg::ST_RANGE;
                state_nxt      = S_OUT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            fba_pkg::OP_TEST: begin
              if (!in_range) begin
                res_nxt.status = fba_pkg::ST_RANGE;
                state_nxt      = S_OUT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              res_nxt.status = fba_pkg::ST_RANGE;
              state_nxt      = S_OUT;
            end
          endcase
        end
      end

      S_SCAN: begin
        // word at addr_r is on the RAM output
        case (op_r)
          fba_pkg::OP_TEST: begin
            res_nxt.frame   = cur_r;
            res_nxt.bit_set = |(word & bmask);
            res_nxt.status  = fba_pkg::ST_OK;
            state_nxt       = S_OUT;
          end
          fba_pkg::OP_FREE: begin
            wr_en          = 1'b1;
            wr_data        = word & ~bmask;
            res_nxt.status = fba_pkg::ST_OK;
            state_nxt      = S_OUT;
          end
          default: begin
            if (!all_used && ({1'b0, found} < lim)) begin
              wr_en                = 1'b1;
              wr_data              = word | (fba_pkg::WORD_BITS'(1) << zpos);
              res_nxt.frame        = found;
              res_nxt.present      = 1'b1;
              res_nxt.write_enable = wr_r;
              res_nxt.user_mode    = !kern_r;
              res_nxt.status       = fba_pkg::ST_OK;
              state_nxt            = S_OUT;
            end else if (all_used && (next_base < lim)) begin
              addr_nxt = next_word[fba_pkg::WIDX_W-1:0];
            end else begin
              res_nxt.status = fba_pkg::ST_NO_FREE;
              state_nxt      = S_OUT;
            end
          end
        endcase
      end

      S_OUT: begin
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      frames_in_use_r <= fba_pkg::LIM_RESET;
      wvld_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_if.valid) frames_in_use_r <= cfg_if.data;
      if (wr_en) wvld_r[addr_r] <= 1'b1;
    end
    op_r      <= op_nxt;
    cur_r     <= cur_nxt;
    kern_r    <= kern_nxt;
    wr_r      <= wr_nxt;
    addr_r    <= addr_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  // bitmap RAM: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) mem[addr_r] <= wr_data;
    rd_data_r <= mem[addr_nxt];
    rd_vld_r  <= wvld_r[addr_nxt];
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.frame        = out_res_r.frame;
  assign out_if.present      = out_res_r.present;
  assign out_if.write_enable = out_res_r.write_enable;
  assign out_if.user_mode    = out_res_r.user_mode;
  assign out_if.bit_set      = out_res_r.bit_set;
  assign out_if.status       = out_res_r.status;

endmodule

// ===== test/frame_bitmap_allocator_checker.sv =====
// Scoreboard for the frame bitmap allocator: watches the request, result and
// frames_in_use channels, keeps its own frame bitmap and checks every result.
// Depends on fba_pkg and the channel interfaces in fba_if.sv.
module frame_bitmap_allocator_checker
  import fba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fba_in_if    in_ch,
  fba_out_if   out_ch,
  fba_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               present;
    logic               write_enable;
    logic               user_mode;
    logic               bit_set;
    logic [STAT_W-1:0]  status;
  } page_result_t;

  logic [MAX_FRAMES-1:0] frame_used;
  logic [LIM_W-1:0]      frames_in_use;
  page_result_t          page_results_q[$];

  // One request against the bitmap; updates frame_used like the block does.
  function automatic page_result_t serve_request(logic [OP_W-1:0] op,
                                                 logic [FRAME_W-1:0] cur,
                                                 logic kern, logic wr);
    page_result_t r;
    int lim;
    int f;
    r   = '0;
    lim = (frames_in_use > LIM_W'(MAX_FRAMES)) ? MAX_FRAMES : int'(frames_in_use);
    case (op)
      OP_ALLOC: begin
        if (cur != '0) begin
          r.frame  = cur;
          r.status = ST_ALREADY;
        end else begin
          f = 0;
          while (f < lim && frame_used[f]) f++;
          if (f >= lim) begin
            r.status = ST_NO_FREE;
          end else begin
            frame_used[f]  = 1'b1;
            r.frame        = FRAME_W'(f);
            r.present      = 1'b1;
            r.write_enable = wr;
            r.user_mode    = ~kern;
            r.status       = ST_OK;
          end
        end
      end
      OP_FREE: begin
        if (cur == '0) begin
          r.status = ST_NOTHING;
        end else if (int'(cur) >= lim) begin
          r.frame  = cur;
          r.status = ST_RANGE;
        end else begin
          frame_used[cur] = 1'b0;
          r.status        = ST_OK;
        end
      end
      OP_TEST: begin
        if (int'(cur) >= lim) begin
          r.status = ST_RANGE;
        end else begin
          r.frame   = cur;
          r.bit_set = frame_used[cur];
          r.status  = ST_OK;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  function automatic int field_check(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v === want_v) return 0;
    $error("%s: expected %0d, got %0d", name, want_v, got_v);
    return 1;
  endfunction

  always @(posedge clk) begin
    page_result_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      frame_used    = '0;
      frames_in_use = LIM_RESET;
      page_results_q.delete();
      pending    <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) frames_in_use = cfg_ch.data;
      // compare before queuing: a request can't be answered in its own cycle
      if (out_ch.valid && out_ch.ready) begin
        if (page_results_q.size() == 0) begin
          $error("result beat with nothing expected: frame %0d status %0d",
                 out_ch.frame, out_ch.status);
          errs++;
        end else begin
          want = page_results_q.pop_front();
          errs += field_check("frame", 16'(want.frame), 16'(out_ch.frame));
          errs += field_check("present", 16'(want.present), 16'(out_ch.present));
          errs += field_check("write_enable", 16'(want.write_enable),
                              16'(out_ch.write_enable));
          errs += field_check("user_mode", 16'(want.user_mode), 16'(out_ch.user_mode));
          errs += field_check("bit_set", 16'(want.bit_set), 16'(out_ch.bit_set));
          errs += field_check("status", 16'(want.status), 16'(out_ch.status));
        end
      end
      if (in_ch.valid && in_ch.ready)
        page_results_q.push_back(serve_request(in_ch.op, in_ch.current_frame,
                                               in_ch.kernel_page, in_ch.writable));
      pending    <= page_results_q.size();
      fail_count <= fail_count + errs;
    end
  end

endmodule

// ===== test/frame_bitmap_allocator_top_test.sv =====
// Top of the frame bitmap allocator test: clock, reset, request and
// frames_in_use stimulus, result back-pressure and the verdict.
// Depends on fba_pkg, fba_if.sv, the block and frame_bitmap_allocator_checker.
module frame_bitmap_allocator_top_test;
  import fba_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;   // unused op code, answered out of range
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 300;             // long receiver hold-off
  localparam int SETTLE_CYCLES = 6;              // block latency margin after the last beat

  logic clk = 1'b0;
  logic rst_n;

  fba_in_if  in_ch();
  fba_out_if out_ch();
  fba_cfg_if cfg_ch();

  int fail_count;
  int pending;

  // Idle knobs. in_idle_pct is only used by the stimulus process; the
  // receiver's knobs are written with NBAs since the receiver reads them.
  int in_idle_pct   = 0;
  int out_stall_pct = 0;
  int hold_asked    = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  frame_bitmap_allocator_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  frame_bitmap_allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stalls, plus a long hold-off whenever the stimulus
  // bumps hold_asked. The hold is counted here, independent of the sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= hold_asked;
    end else if (hold_taken != hold_asked) begin
      hold_taken   <= hold_asked;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  // Offer one request and return at the edge where its beat is taken.
  // valid stays high across back-to-back beats; it is only lowered when a
  // gap is chosen, so it never sees two NBAs in one step.
  task automatic send_req(logic [OP_W-1:0] op, logic [FRAME_W-1:0] cur,
                          logic kern, logic wr);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.current_frame <= cur;
    in_ch.kernel_page   <= kern;
    in_ch.writable      <= wr;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait for every expected result. The first edge is
  // skipped so the checker's count already includes the last beat.
  task automatic wait_until_quiet();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frames_in_use changes only with the block idle.
  task automatic set_frames_in_use(int value);
    wait_until_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= LIM_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idle_mode(int mode);
    case (mode)
      0: begin in_idle_pct = 0;  out_stall_pct <= 0;  end
      1: begin in_idle_pct = 59; out_stall_pct <= 0;  end
      2: begin in_idle_pct = 0;  out_stall_pct <= 59; end
      default: begin in_idle_pct = 34; out_stall_pct <= 34; end
    endcase
  endtask

  // Random phase at one frames_in_use setting. Allocation share is a knob so
  // some phases fill the bitmap (and hit the full case) while others churn.
  // Free/test frames lean toward the region that allocations have reached.
  task automatic random_phase(int lim_val, int n_items, int alloc_pct, int mode,
                              bit hold);
    int lim_eff;
    int near_top;
    int pick;
    logic [OP_W-1:0] op;
    logic [FRAME_W-1:0] cur;
    set_frames_in_use(lim_val);
    set_idle_mode(mode);
    if (hold) hold_asked <= hold_asked + 1;
    lim_eff  = (lim_val > MAX_FRAMES) ? MAX_FRAMES : lim_val;
    near_top = (lim_eff < 300) ? lim_eff + 2 : 300;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        op  = OP_ALLOC;
        cur = ($urandom_range(0, 9) < 8) ? '0 : FRAME_W'($urandom_range(1, 4095));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      op = OP_FREE;
        else if (pick < 90) op = OP_TEST;
        else                op = OP_UNDEF;
        cur = ($urandom_range(0, 9) < 6) ? FRAME_W'($urandom_range(0, near_top))
                                         : FRAME_W'($urandom());
      end
      send_req(op, cur, 1'($urandom()), 1'($urandom()));
    end
  endtask

  initial begin
    #(LIMIT_CYCLES * 10);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_ALLOC;
    in_ch.current_frame <= '0;
    in_ch.kernel_page   <= 1'b0;
    in_ch.writable      <= 1'b0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, frames_in_use at its reset value of 4096.
    send_req(OP_TEST,  12'd0,    1'b0, 1'b0);   // clear after reset
    send_req(OP_ALLOC, 12'd0,    1'b0, 1'b1);   // frame zero is allocatable
    send_req(OP_ALLOC, 12'd0,    1'b1, 1'b0);   // next frame, kernel page
    send_req(OP_ALLOC, 12'hFFF,  1'b1, 1'b1);   // entry already holds a frame
    send_req(OP_ALLOC, 12'h800,  1'b0, 1'b0);
    send_req(OP_TEST,  12'd0,    1'b1, 1'b1);
    send_req(OP_TEST,  12'hFFF,  1'b0, 1'b0);   // top frame, in range
    send_req(OP_FREE,  12'd0,    1'b0, 1'b0);   // nothing to free
    send_req(OP_FREE,  12'd1,    1'b0, 1'b0);
    send_req(OP_ALLOC, 12'd0,    1'b0, 1'b1);   // first fit takes frame 1 back
    send_req(OP_FREE,  12'hFFF,  1'b1, 1'b1);   // free of an unused frame
    send_req(OP_UNDEF, 12'hFFF,  1'b1, 1'b1);
    send_req(OP_TEST,  12'd2,    1'b0, 1'b0);

    // Two frames managed: the bitmap is already full, range edge at 2.
    set_frames_in_use(2);
    send_req(OP_ALLOC, 12'd0,    1'b0, 1'b1);
    send_req(OP_FREE,  12'd2,    1'b0, 1'b0);
    send_req(OP_TEST,  12'd2,    1'b0, 1'b0);
    send_req(OP_TEST,  12'd1,    1'b0, 1'b0);
    send_req(OP_FREE,  12'd1,    1'b0, 1'b0);
    send_req(OP_ALLOC, 12'd0,    1'b1, 1'b1);

    // No frames managed at all.
    set_frames_in_use(0);
    send_req(OP_ALLOC, 12'd0,    1'b0, 1'b0);
    send_req(OP_FREE,  12'd0,    1'b0, 1'b0);
    send_req(OP_FREE,  12'd5,    1'b0, 1'b0);
    send_req(OP_TEST,  12'd0,    1'b0, 1'b0);
    send_req(OP_UNDEF, 12'd0,    1'b0, 1'b0);

    // Random phases. The first one starts with a long result hold-off while
    // requests keep coming, so the block backs up and stalls its input.
    random_phase(8191, 80, 85, 0, 1'b1);
    random_phase(40,   60, 55, 1, 1'b0);
    random_phase(1,    25, 50, 2, 1'b0);
    random_phase(4097, 80, 70, 3, 1'b0);
    random_phase(97,   70, 55, 0, 1'b1);
    random_phase(0,    20, 40, 1, 1'b0);
    random_phase(64,   70, 60, 2, 1'b0);
    random_phase(4096, 90, 75, 3, 1'b0);
    random_phase(300,  60, 55, 0, 1'b0);
    random_phase(33,   45, 55, 1, 1'b0);

    wait_until_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
